>>> rtl/gregorian_date_step_unit_defines.svh
// Assertion macros for the Gregorian date step unit.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef GREGORIAN_DATE_STEP_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_STEP_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GDSU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define GDSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gdsu_pkg.sv
// Types, month codes and calendar helpers for the Gregorian date step unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gdsu_pkg;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [4:0] DAYS_LONG  = 5'd31;
	localparam logic [4:0] DAYS_SHORT = 5'd30;
	localparam logic [4:0] DAYS_LEAP  = 5'd29;
	localparam logic [4:0] DAYS_FEB   = 5'd28;

	// floor(year / 25) as (year * Recip25) >> RecipShift, exact for 14-bit years
	localparam logic [14:0] Recip25    = 15'd20972;
	localparam int          RecipShift = 19;

	localparam int TDATA_IN_W  = 24;
	localparam int TDATA_OUT_W = 64;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [5:0]  day;
	} gdsu_date_t;

	typedef struct packed {
		logic        date_valid;
		logic [4:0]  month_length;
		logic [8:0]  day_of_year;
		logic [4:0]  prev_day;
		logic [3:0]  prev_month;
		logic [13:0] prev_year;
		logic [4:0]  next_day;
		logic [3:0]  next_month;
		logic [13:0] next_year;
	} gdsu_result_t;

	function automatic logic gdsu_is_leap(input logic [13:0] year);
		logic [28:0] prod;
		logic [9:0]  quo;
		logic [13:0] back;
		logic        by25;
		prod = 29'(year) * 29'(Recip25);
		quo  = prod[28:RecipShift];
		back = 14'(quo) * 14'd25;
		by25 = (back == year);
		return (year[1:0] == 2'd0) && (!by25 || (year[3:0] == 4'd0));
	endfunction

	function automatic logic [4:0] gdsu_month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
			MONTH_FEB: len = leap ? DAYS_LEAP : DAYS_FEB;
			default: len = DAYS_LONG;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] gdsu_days_before(input logic [3:0] month);
		logic [8:0] days;
		case (month)
			4'd1:  days = 9'd0;
			4'd2:  days = 9'd31;
			4'd3:  days = 9'd59;
			4'd4:  days = 9'd90;
			4'd5:  days = 9'd120;
			4'd6:  days = 9'd151;
			4'd7:  days = 9'd181;
			4'd8:  days = 9'd212;
			4'd9:  days = 9'd243;
			4'd10: days = 9'd273;
			4'd11: days = 9'd304;
			4'd12: days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

`default_nettype wire

>>> rtl/gregorian_date_step_unit.sv
// Gregorian date step unit: input register, date logic, result register.
// Depends on gdsu_pkg, gdsu_calc and gregorian_date_step_unit_defines.svh.
// Throughput: one beat per cycle, set by the two-register stream pipeline,
// as long as m_tready low does not stall the output.
// Reset: arst_n low empties both stages at once; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "gregorian_date_step_unit_defines.svh"

module gregorian_date_step_unit import gdsu_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [TDATA_IN_W-1:0]  s_tdata,  // day[5:0], month[9:6], year[23:10]
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// month_length[4:0], day_of_year[13:5], prev_day[18:14], prev_month[22:19],
	// prev_year[36:23], next_day[41:37], next_month[45:42], next_year[59:46], zero[63:60]
	output logic [TDATA_OUT_W-1:0]      m_tdata,
	output logic                        m_tuser   // date_valid
);

	gdsu_date_t   date_in;
	gdsu_date_t   date_s1;
	gdsu_result_t res;
	gdsu_result_t res_s2;
	logic         valid_s1;
	logic         valid_s2;
	logic         adv_s1;

	assign date_in.day   = s_tdata[5:0];
	assign date_in.month = s_tdata[9:6];
	assign date_in.year  = s_tdata[23:10];

	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv_s1) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) date_s1 <= date_in;
		if (valid_s1 && adv_s1) res_s2 <= res;
	end

	gdsu_calc u_calc (
		.date (date_s1),
		.res  (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.date_valid;
	assign m_tdata  = {4'd0, res_s2.next_year, res_s2.next_month, res_s2.next_day,
		res_s2.prev_year, res_s2.prev_month, res_s2.prev_day,
		res_s2.day_of_year, res_s2.month_length};

	`GDSU_ASSERT_NEXT(a_in_beat_fills_s1, s_tvalid && s_tready, valid_s1, "beat lost at stage 1")
	`GDSU_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv_s1, valid_s1 && $stable(date_s1),
		"stage 1 changed while stalled")
	`GDSU_ASSERT_NOW(a_invalid_zero, m_tvalid && !m_tuser, m_tdata == 64'd0,
		"invalid date with nonzero result")
	`GDSU_ASSERT_NOW(a_valid_month_len, m_tvalid && m_tuser,
		(res_s2.month_length >= DAYS_FEB) && (res_s2.next_day != 5'd0),
		"valid date with bad month length or next day")

endmodule

`default_nettype wire

>>> rtl/gdsu_calc.sv
// Combinational date logic: validity, month length, ordinal day, previous and next date.
// Depends on gdsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdsu_calc import gdsu_pkg::*; (
	input  gdsu_date_t   date,
	output gdsu_result_t res
);

	logic       leap;
	logic [4:0] mlen;
	logic [3:0] prev_mon;
	logic [4:0] prev_len;
	logic [4:0] day5;
	logic       valid;

	assign leap     = gdsu_is_leap(date.year);
	assign mlen     = gdsu_month_len(date.month, leap);
	assign prev_mon = date.month - 4'd1;
	assign prev_len = gdsu_month_len(prev_mon, leap);
	assign day5     = date.day[4:0];
	assign valid    = (date.day != 6'd0) && (date.month != 4'd0) && (date.month <= MONTH_DEC) &&
		(date.year != 14'd0) && (date.day <= {1'b0, mlen});

	always_comb begin
		res = '0;
		if (valid) begin
			res.date_valid   = 1'b1;
			res.month_length = mlen;
			res.day_of_year  = gdsu_days_before(date.month) + 9'(day5) +
				9'((date.month > MONTH_FEB) && leap);
			if (day5 == 5'd1) begin
				if (date.month == MONTH_JAN) begin
					res.prev_day   = DAYS_LONG;
					res.prev_month = MONTH_DEC;
					res.prev_year  = date.year - 14'd1;
				end else begin
					res.prev_day   = prev_len;
					res.prev_month = prev_mon;
					res.prev_year  = date.year;
				end
			end else begin
				res.prev_day   = day5 - 5'd1;
				res.prev_month = date.month;
				res.prev_year  = date.year;
			end
			if (day5 == mlen) begin
				res.next_day = 5'd1;
				if (date.month == MONTH_DEC) begin
					res.next_month = MONTH_JAN;
					res.next_year  = date.year + 14'd1;
				end else begin
					res.next_month = date.month + 4'd1;
					res.next_year  = date.year;
				end
			end else begin
				res.next_day   = day5 + 5'd1;
				res.next_month = date.month;
				res.next_year  = date.year;
			end
		end
	end

endmodule

`default_nettype wire
